// ===== hdl/afd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afd_pkg
// Shared types and constants of the accelerometer fall detector.
// ============================================================================
package afd_pkg;

    // Configuration port address width: five registers at a 4-byte stride.
    localparam int unsigned ADDR_W = 5;

    // Register indexes (byte address / 4).
    typedef enum logic [2:0] {
        REG_FREEFALL_LEVEL_SQ = 3'd0,
        REG_IMPACT_LEVEL_SQ   = 3'd1,
        REG_FREEFALL_MIN_MS   = 3'd2,
        REG_WINDOW_MS         = 3'd3,
        REG_HOLD_MS           = 3'd4
    } t_reg_idx;

    // Register reset values.
    localparam logic [31:0] RST_FREEFALL_LEVEL_SQ = 32'd10737418;
    localparam logic [31:0] RST_IMPACT_LEVEL_SQ   = 32'd104857600;
    localparam logic [15:0] RST_FREEFALL_MIN_MS   = 16'd150;
    localparam logic [15:0] RST_WINDOW_MS         = 16'd500;
    localparam logic [15:0] RST_HOLD_MS           = 16'd3000;

    // Classified sample handed from the magnitude pipeline to the detector.
    typedef struct packed {
        logic        free_fall;  // squared magnitude below the free fall level
        logic        impact;     // squared magnitude above the impact level
        logic        clear;
        logic [31:0] time_ms;
    } t_cls;

endpackage

// ===== hdl/afd_sample_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afd_sample_if
// Valid/ready channel carrying one timestamped accelerometer sample.
// ============================================================================
interface afd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] time_ms;
    logic               clear;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, clear,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, clear,
                    output ready);
endinterface

// ===== hdl/afd_result_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afd_result_if
// Valid/ready channel carrying one fall detector result.
// ============================================================================
interface afd_result_if;
    logic valid;
    logic ready;
    logic fall_detected;
    logic fall_active;
    logic in_freefall;
    logic in_window;

    modport source (output valid, fall_detected, fall_active, in_freefall,
                    in_window, input ready);
    modport sink   (input valid, fall_detected, fall_active, in_freefall,
                    in_window, output ready);
endinterface

// ===== hdl/afd_mag_pipe.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afd_mag_pipe
// Three-stage pipeline: input register, per-axis squares, sum and threshold
// compares. Each stage loads when it is empty or its successor loads.
// ============================================================================
module afd_mag_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    afd_sample_if.sink           i_sample,
    input  logic [31:0]          i_freefall_level_sq,
    input  logic [31:0]          i_impact_level_sq,
    output logic                 o_cls_valid,
    input  logic                 i_cls_ready,
    output afd_pkg::t_cls        o_cls
);
    import afd_pkg::*;

    // Stage 1: registered sample.
    logic               r_v1;
    logic signed [15:0] r_x, r_y, r_z;
    logic        [31:0] r_t1;
    logic               r_c1;
    // Stage 2: squares.
    logic               r_v2;
    logic        [30:0] r_sx, r_sy, r_sz;
    logic        [31:0] r_t2;
    logic               r_c2;
    // Stage 3: classification.
    logic               r_v3;
    t_cls               r_cls;

    logic               rdy1, rdy2, rdy3;
    logic        [31:0] mag_sq;

    // Magnitude of a signed 16-bit value; -32768 gives 32768.
    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic [30:0] sq17(input logic [16:0] m);
        logic [33:0] p;
        p = m * m;
        return p[30:0];
    endfunction

    assign rdy3 = !r_v3 || i_cls_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_sample.ready = rdy1;

    assign mag_sq = 32'(r_sx) + 32'(r_sy) + 32'(r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_sample.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_sample.valid) begin
            r_x  <= i_sample.accel_x;
            r_y  <= i_sample.accel_y;
            r_z  <= i_sample.accel_z;
            r_t1 <= i_sample.time_ms;
            r_c1 <= i_sample.clear;
        end
        if (rdy2 && r_v1) begin
            r_sx <= sq17(abs17(r_x));
            r_sy <= sq17(abs17(r_y));
            r_sz <= sq17(abs17(r_z));
            r_t2 <= r_t1;
            r_c2 <= r_c1;
        end
        if (rdy3 && r_v2) begin
            r_cls.free_fall <= mag_sq < i_freefall_level_sq;
            r_cls.impact    <= mag_sq > i_impact_level_sq;
            r_cls.clear     <= r_c2;
            r_cls.time_ms   <= r_t2;
        end
    end

    assign o_cls_valid = r_v3;
    assign o_cls       = r_cls;

endmodule

// ===== hdl/accel_fall_detector_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// accel_fall_detector_core
// Two-stage fall detector on timestamped three-axis accelerometer samples.
// ============================================================================
//
//  Channel    Direction  Handshake        Payload
//  i_sample   in         valid / ready    accel_x/y/z, time_ms, clear
//  o_result   out        valid / ready    fall_detected, fall_active,
//                                         in_freefall, in_window
//  APB        in         psel/penable     paddr, pwdata, prdata (32 bit)
//
// One item enters per cycle while the result side is not stalling. The four
// registers an item passes through are the input register, the squares, the
// sum and compare, and the detector update into the result register. The
// detector state loop closes in the last stage only, so the next item can
// follow in the very next cycle.
// Reset is synchronous and active low; it clears the pipeline valid bits,
// the detector flags and loads the register defaults.
// Each stage loads whenever it is empty or its successor loads. A stalled
// result lets the earlier stages keep taking items until all four stages
// hold one, after which the input is stalled as well.
//
// Behaviour in brief. The squared magnitude of each sample is compared with
// two squared thresholds, so no square root is needed. While the magnitude
// is below the free fall level the free fall flag is set and its start time
// kept; once free fall has lasted the minimum time the impact window opens.
// An impact (magnitude above the impact level) inside the window confirms a
// fall, closes the window and drops free fall. A window that has been open
// longer than its length closes and also drops free fall. A confirmed fall
// stays active until more than the hold time has passed. All time
// differences wrap modulo 2^32. A clear item resets every flag and time and
// yields an all-zero result.
// ============================================================================
module accel_fall_detector_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    afd_sample_if.sink                  i_sample,
    afd_result_if.source                o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import afd_pkg::*;

    // Configuration registers.
    logic [31:0] r_freefall_level_sq;
    logic [31:0] r_impact_level_sq;
    logic [15:0] r_freefall_min_ms;
    logic [15:0] r_window_ms;
    logic [15:0] r_hold_ms;

    // Classified samples from the magnitude pipeline.
    logic        cls_valid;
    logic        cls_ready;
    t_cls        cls;

    // Detector state.
    logic        r_ff_flag,   n_ff_flag;
    logic [31:0] r_ff_start,  n_ff_start;
    logic        r_win_flag,  n_win_flag;
    logic [31:0] r_win_start, n_win_start;
    logic        r_cf_flag,   n_cf_flag;
    logic [31:0] r_cf_time,   n_cf_time;
    logic        n_detected;

    // Result register.
    logic        r_out_valid;
    logic        r_fall_detected;

    logic        cfg_wr;
    logic        take;

    // ------------------------------------------------------------------
    // Configuration port. The low address bits are not decoded; indexes
    // beyond the last register are ignored on write and read as zero.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freefall_level_sq <= RST_FREEFALL_LEVEL_SQ;
            r_impact_level_sq   <= RST_IMPACT_LEVEL_SQ;
            r_freefall_min_ms   <= RST_FREEFALL_MIN_MS;
            r_window_ms         <= RST_WINDOW_MS;
            r_hold_ms           <= RST_HOLD_MS;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_FREEFALL_LEVEL_SQ: r_freefall_level_sq <= pwdata;
                REG_IMPACT_LEVEL_SQ:   r_impact_level_sq   <= pwdata;
                REG_FREEFALL_MIN_MS:   r_freefall_min_ms   <= pwdata[15:0];
                REG_WINDOW_MS:         r_window_ms         <= pwdata[15:0];
                REG_HOLD_MS:           r_hold_ms           <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_FREEFALL_LEVEL_SQ: prdata = r_freefall_level_sq;
            REG_IMPACT_LEVEL_SQ:   prdata = r_impact_level_sq;
            REG_FREEFALL_MIN_MS:   prdata = 32'(r_freefall_min_ms);
            REG_WINDOW_MS:         prdata = 32'(r_window_ms);
            REG_HOLD_MS:           prdata = 32'(r_hold_ms);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Squares, sum and threshold compares.
    // ------------------------------------------------------------------
    afd_mag_pipe u_mag (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sample            (i_sample),
        .i_freefall_level_sq (r_freefall_level_sq),
        .i_impact_level_sq   (r_impact_level_sq),
        .o_cls_valid         (cls_valid),
        .i_cls_ready         (cls_ready),
        .o_cls               (cls)
    );

    // The result register takes a new item when it is empty or being read.
    assign cls_ready = !r_out_valid || o_result.ready;
    assign take      = cls_valid && cls_ready;

    // ------------------------------------------------------------------
    // Detector update. The steps run in order: free fall tracking, then
    // the window and impact checks, then hold expiry, each seeing the
    // values the step before it left. Start times written in this step
    // give a zero difference to the checks after them.
    // ------------------------------------------------------------------
    always_comb begin
        n_ff_flag   = r_ff_flag;
        n_ff_start  = r_ff_start;
        n_win_flag  = r_win_flag;
        n_win_start = r_win_start;
        n_cf_flag   = r_cf_flag;
        n_cf_time   = r_cf_time;
        n_detected  = 1'b0;

        if (cls.clear) begin
            n_ff_flag   = 1'b0;
            n_ff_start  = '0;
            n_win_flag  = 1'b0;
            n_win_start = '0;
            n_cf_flag   = 1'b0;
            n_cf_time   = '0;
        end else begin
            if (cls.free_fall) begin
                if (!n_ff_flag) begin
                    n_ff_flag  = 1'b1;
                    n_ff_start = cls.time_ms;
                end
                if ((cls.time_ms - n_ff_start) >= 32'(r_freefall_min_ms)
                        && !n_win_flag) begin
                    n_win_flag  = 1'b1;
                    n_win_start = cls.time_ms;
                end
            end else begin
                n_ff_flag = 1'b0;
            end

            if (n_win_flag) begin
                priority if (cls.impact) begin
                    n_cf_flag  = 1'b1;
                    n_cf_time  = cls.time_ms;
                    n_win_flag = 1'b0;
                    n_ff_flag  = 1'b0;
                    n_detected = 1'b1;
                end else if ((cls.time_ms - n_win_start) > 32'(r_window_ms)) begin
                    n_win_flag = 1'b0;
                    n_ff_flag  = 1'b0;
                end else begin
                    // Neither impact nor timeout: the window stays open.
                    n_win_flag = 1'b1;
                end
            end

            if (n_cf_flag && (cls.time_ms - n_cf_time) > 32'(r_hold_ms)) begin
                n_cf_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_flag   <= 1'b0;
            r_ff_start  <= '0;
            r_win_flag  <= 1'b0;
            r_win_start <= '0;
            r_cf_flag   <= 1'b0;
            r_cf_time   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_ff_flag   <= n_ff_flag;
                r_ff_start  <= n_ff_start;
                r_win_flag  <= n_win_flag;
                r_win_start <= n_win_start;
                r_cf_flag   <= n_cf_flag;
                r_cf_time   <= n_cf_time;
            end
            if (cls_ready) begin
                r_out_valid <= cls_valid;
            end
        end
    end

    // The flag outputs are the state itself; only the detection pulse
    // needs a register of its own.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_fall_detected <= n_detected;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.fall_detected = r_fall_detected;
    assign o_result.fall_active   = r_cf_flag;
    assign o_result.in_freefall   = r_ff_flag;
    assign o_result.in_window     = r_win_flag;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A detected fall starts its hold on the same sample, so it is active.
    a_detect_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fall_detected |-> r_cf_flag)
        else $error("detected fall not reported active");

    // Confirming an impact closes the window and ends free fall.
    a_detect_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fall_detected |-> !r_win_flag && !r_ff_flag)
        else $error("window or free fall left open after impact");

    // A classified sample held back by the result register stays intact.
    a_cls_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cls_valid && !cls_ready |=> cls_valid && $stable(cls))
        else $error("classified sample changed while stalled");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the accelerometer fall detector core.
// ============================================================================
// Samples go in over the sample channel and results come back over the
// result channel. A small scoreboard keeps its own copy of the detector
// state and the five registers, predicts one result for every accepted item
// and compares each returned result with the oldest prediction, field by
// field. The run opens with hand-built samples under the reset settings, then
// walks through several register settings (the extremes among them) with
// mostly well-formed fall sequences, some noise and some clears. Both
// channels idle at random, and the last phase runs without idling.
// ============================================================================
module tb;
    import afd_pkg::*;

    // Top of the legal range for the two squared levels (3 * 2^30).
    localparam logic [31:0] LEVEL_TOP = 32'hC000_0000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic        [31:0] time_ms;
        logic               clear;
    } t_sample;

    typedef struct packed {
        logic fall_detected;
        logic fall_active;
        logic in_freefall;
        logic in_window;
    } t_verdict;

    // What a generated sample is meant to look like against the current levels.
    typedef enum {K_FREEFALL, K_IMPACT, K_ORDINARY, K_NOISE} t_kind;

    // ------------------------------------------------------------------------
    // Scoreboard: fall detector prediction plus the queue of pending verdicts.
    // ------------------------------------------------------------------------
    class fall_scoreboard;
        logic [31:0] ff_level;
        logic [31:0] imp_level;
        logic [15:0] ff_min;
        logic [15:0] win_len;
        logic [15:0] hold_len;
        bit          ff_flag;
        bit          win_flag;
        bit          conf_flag;
        logic [31:0] ff_start;
        logic [31:0] win_start;
        logic [31:0] conf_time;
        t_verdict    verdict_q[$];
        int          errors;

        function new();
            ff_level  = RST_FREEFALL_LEVEL_SQ;
            imp_level = RST_IMPACT_LEVEL_SQ;
            ff_min    = RST_FREEFALL_MIN_MS;
            win_len   = RST_WINDOW_MS;
            hold_len  = RST_HOLD_MS;
            errors    = 0;
            clear_state();
        endfunction

        function void clear_state();
            ff_flag   = 1'b0;
            win_flag  = 1'b0;
            conf_flag = 1'b0;
            ff_start  = '0;
            win_start = '0;
            conf_time = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_FREEFALL_LEVEL_SQ: ff_level  = val;
                REG_IMPACT_LEVEL_SQ:   imp_level = val;
                REG_FREEFALL_MIN_MS:   ff_min    = val[15:0];
                REG_WINDOW_MS:         win_len   = val[15:0];
                REG_HOLD_MS:           hold_len  = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] axis_sq(logic signed [15:0] v);
            logic [31:0] mag;
            mag = v[15] ? 32'h0001_0000 - {16'h0000, v} : {16'h0000, v};
            return mag * mag;
        endfunction

        // Works out the verdict of one accepted sample and queues it.
        function void note_sample(t_sample s);
            logic [31:0] mag_sq;
            t_verdict    v;
            v = '0;
            if (s.clear) begin
                clear_state();
            end else begin
                mag_sq = axis_sq(s.accel_x) + axis_sq(s.accel_y) + axis_sq(s.accel_z);
                if (mag_sq < ff_level) begin
                    if (!ff_flag) begin
                        ff_flag  = 1'b1;
                        ff_start = s.time_ms;
                    end
                    if (32'(s.time_ms - ff_start) >= {16'h0000, ff_min} && !win_flag) begin
                        win_flag  = 1'b1;
                        win_start = s.time_ms;
                    end
                end else begin
                    ff_flag = 1'b0;
                end
                if (win_flag) begin
                    if (mag_sq > imp_level) begin
                        conf_flag       = 1'b1;
                        conf_time       = s.time_ms;
                        win_flag        = 1'b0;
                        ff_flag         = 1'b0;
                        v.fall_detected = 1'b1;
                    end else if (32'(s.time_ms - win_start) > {16'h0000, win_len}) begin
                        win_flag = 1'b0;
                        ff_flag  = 1'b0;
                    end
                end
                if (conf_flag && 32'(s.time_ms - conf_time) > {16'h0000, hold_len}) begin
                    conf_flag = 1'b0;
                end
                v.fall_active = conf_flag;
                v.in_freefall = ff_flag;
                v.in_window   = win_flag;
            end
            verdict_q.push_back(v);
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task match_field(string name, logic got, logic want);
            if (got !== want) begin
                report($sformatf("%s is %b, predicted %b", name, got, want));
            end
        endtask

        task check_result(t_verdict got);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                report($sformatf("result %b arrived with no item outstanding", got));
            end else begin
                want = verdict_q.pop_front();
                match_field("fall_detected", got.fall_detected, want.fall_detected);
                match_field("fall_active", got.fall_active, want.fall_active);
                match_field("in_freefall", got.in_freefall, want.in_freefall);
                match_field("in_window", got.in_window, want.in_window);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block itself.
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    afd_sample_if smp_if ();
    afd_result_if res_if ();

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    accel_fall_detector_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fall_scoreboard board;

    // Running sample clock in milliseconds; it wraps just as the block's does.
    logic [31:0] now_ms;
    int unsigned sent;
    // Idling odds: one chance in N per item or per cycle, 0 meaning no idling.
    int unsigned gap_rate;
    int unsigned stall_rate;
    // Asks the result side for one long hold-off, so the pipeline fills up.
    bit          long_hold_req;
    bit          calm;

    // ------------------------------------------------------------------------
    // Sample shaping. The generator aims each sample at one side of the
    // current levels, so that fall sequences really get through both stages.
    // ------------------------------------------------------------------------
    function automatic int unsigned root_floor(logic [31:0] v);
        int unsigned     r;
        int unsigned     t;
        longint unsigned t_sq;
        int              b;
        r = 0;
        for (b = 15; b >= 0; b--) begin
            t    = r | (32'd1 << b);
            t_sq = longint'(t) * longint'(t);
            if (t_sq <= {32'h0, v}) begin
                r = t;
            end
        end
        return r;
    endfunction

    // A count of the given magnitude with a random sign; 32768 maps to -32768.
    function automatic logic signed [15:0] pick_axis(int unsigned mag);
        logic signed [15:0] a;
        if (mag >= 32768) begin
            return 16'sh8000;
        end
        a = mag[15:0];
        return ($urandom_range(0, 1) == 1) ? -a : a;
    endfunction

    function automatic t_sample shape_sample(t_kind kind);
        t_sample            s;
        int unsigned        m;
        int unsigned        lo;
        logic signed [15:0] big;
        s.time_ms = now_ms;
        s.clear   = 1'b0;
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        case (kind)
            K_FREEFALL: begin
                // Each axis small enough that three of them stay below the level.
                if (board.ff_level != 0) begin
                    m = root_floor((board.ff_level - 1) / 3);
                    s.accel_x = pick_axis($urandom_range(0, m));
                    s.accel_y = pick_axis($urandom_range(0, m));
                    s.accel_z = pick_axis($urandom_range(0, m));
                end
            end
            K_IMPACT: begin
                // One axis alone clears the impact level where that is possible;
                // otherwise the largest magnitude of all is the best try.
                lo = root_floor(board.imp_level) + 1;
                if (lo > 32768) begin
                    s.accel_x = 16'sh8000;
                    s.accel_y = 16'sh8000;
                    s.accel_z = 16'sh8000;
                end else begin
                    big = pick_axis($urandom_range(lo, 32768));
                    case ($urandom_range(0, 2))
                        0:       s.accel_x = big;
                        1:       s.accel_y = big;
                        default: s.accel_z = big;
                    endcase
                end
            end
            K_ORDINARY: begin
                // Roughly one g on z with a little sway on the other two axes.
                s.accel_x = pick_axis($urandom_range(0, 600));
                s.accel_y = pick_axis($urandom_range(0, 600));
                s.accel_z = pick_axis($urandom_range(3600, 4600));
            end
            default: ;
        endcase
        return s;
    endfunction

    // Moves the sample clock forward to the target, never backwards.
    function automatic void advance_to(logic [31:0] target);
        logic [31:0] delta;
        delta = target - now_ms;
        if (!delta[31]) begin
            now_ms = target;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered just after a rising edge and drives with
    // nonblocking assignments, so the block sees stable inputs at the next one.
    // ------------------------------------------------------------------------
    task automatic send_item(t_sample s);
        if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.accel_x <= s.accel_x;
        smp_if.accel_y <= s.accel_y;
        smp_if.accel_z <= s.accel_z;
        smp_if.time_ms <= s.time_ms;
        smp_if.clear   <= s.clear;
        do @(posedge i_clk); while (smp_if.ready !== 1'b1);
        board.note_sample(s);
        sent++;
    endtask

    task automatic put(int x, int y, int z, logic [31:0] t, logic clr);
        t_sample s;
        now_ms    = t;
        s.accel_x = x[15:0];
        s.accel_y = y[15:0];
        s.accel_z = z[15:0];
        s.time_ms = t;
        s.clear   = clr;
        send_item(s);
    endtask

    // Drops valid and holds the sample side back until every pending verdict
    // has been returned. It always waits for a rising edge first, so a following
    // send never raises valid in the step in which it was lowered.
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.verdict_q.size() != 0);
    endtask

    // One register write: setup cycle, then access cycle until pready. The
    // select is left high so that writes can follow back to back; reconfigure
    // lowers it once the last one is done.
    task automatic cfg_write(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.set_reg(idx, val);
    endtask

    // Registers change only with the block empty.
    task automatic reconfigure(logic [31:0] ff, logic [31:0] imp, logic [15:0] ff_min,
                               logic [15:0] win, logic [15:0] hold);
        wait_drained();
        cfg_write(REG_FREEFALL_LEVEL_SQ, ff);
        cfg_write(REG_IMPACT_LEVEL_SQ, imp);
        cfg_write(REG_FREEFALL_MIN_MS, {16'h0000, ff_min});
        cfg_write(REG_WINDOW_MS, {16'h0000, win});
        cfg_write(REG_HOLD_MS, {16'h0000, hold});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LEVEL_TOP;
            2:       return $urandom_range(0, LEVEL_TOP);
            default: return $urandom_range(1_000_000, 150_000_000);
        endcase
    endfunction

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 800));
        endcase
    endfunction

    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 5;
            default: return 12;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random sequences.
    // ------------------------------------------------------------------------

    // A well-formed fall: a little ordinary motion, free fall spread over the
    // minimum time (now and then just short of it or broken by ordinary
    // samples), up to two samples in the window, an impact in it or at or
    // past its end, and a tail that straddles the end of the hold time.
    task automatic fall_sequence();
        logic [31:0] start;
        logic [31:0] open_at;
        logic [31:0] target;
        logic [31:0] anchor;
        int unsigned n_ff;
        int unsigned k;
        n_ff = $urandom_range(1, 5);
        repeat ($urandom_range(0, 2)) begin
            now_ms = now_ms + $urandom_range(1, 40);
            send_item(shape_sample(K_ORDINARY));
        end
        now_ms = now_ms + $urandom_range(1, 40);
        start  = now_ms;
        send_item(shape_sample(K_FREEFALL));
        for (k = 1; k <= n_ff; k++) begin
            target = start + (board.ff_min * k) / n_ff;
            if (k == n_ff && board.ff_min != 0 && $urandom_range(0, 5) == 0) begin
                target = target - 1;
            end
            advance_to(target);
            send_item(shape_sample(($urandom_range(0, 19) == 0) ? K_ORDINARY : K_FREEFALL));
        end
        open_at = start + board.ff_min;
        repeat ($urandom_range(0, 2)) begin
            advance_to(now_ms + $urandom_range(0, board.win_len / 3));
            send_item(shape_sample(($urandom_range(0, 2) == 0) ? K_FREEFALL : K_ORDINARY));
        end
        case ($urandom_range(0, 4))
            0:       target = open_at + board.win_len;
            1:       target = open_at + board.win_len + 1;
            2:       target = open_at + board.win_len + $urandom_range(2, 5000);
            default: target = open_at + $urandom_range(0, board.win_len);
        endcase
        advance_to(target);
        send_item(shape_sample(($urandom_range(0, 5) == 0) ? K_ORDINARY : K_IMPACT));
        anchor = now_ms;
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
                0:       target = anchor + board.hold_len;
                1:       target = anchor + board.hold_len + 1;
                default: target = anchor + $urandom_range(0, 2 * board.hold_len + 2);
            endcase
            advance_to(target);
            send_item(shape_sample(K_ORDINARY));
        end
    endtask

    // Random bits, with time jumping anywhere, stepping back or creeping on.
    task automatic noise_burst();
        t_sample s;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0:       now_ms = $urandom;
                1:       now_ms = now_ms - $urandom_range(1, 2000);
                default: now_ms = now_ms + $urandom_range(0, 3000);
            endcase
            s = shape_sample(t_kind'($urandom_range(0, 3)));
            send_item(s);
        end
    endtask

    task automatic send_clear();
        t_sample s;
        s       = shape_sample(K_NOISE);
        s.clear = 1'b1;
        send_item(s);
    endtask

    task automatic run_phase(int unsigned target);
        while (sent < target) begin
            if (!calm) begin
                gap_rate   = pick_rate();
                stall_rate = pick_rate();
            end
            case ($urandom_range(0, 19))
                0, 1, 2: noise_burst();
                3:       send_clear();
                default: fall_sequence();
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks every accepted result and stalls in random bursts.
    // A long hold-off, once asked for, is counted down here in cycles.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        t_verdict    got;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = {res_if.fall_detected, res_if.fall_active,
                       res_if.in_freefall, res_if.in_window};
                board.check_result(got);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 80;
            end else if (stall_left == 0 && stall_rate != 0
                         && $urandom_range(1, stall_rate) == 1) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        board         = new();
        now_ms        = '0;
        sent          = 0;
        gap_rate      = 0;
        stall_rate    = 0;
        long_hold_req = 1'b0;
        calm          = 1'b0;
        i_rst_n        <= 1'b0;
        smp_if.valid   <= 1'b0;
        smp_if.accel_x <= '0;
        smp_if.accel_y <= '0;
        smp_if.accel_z <= '0;
        smp_if.time_ms <= '0;
        smp_if.clear   <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-built samples under the reset settings: largest magnitudes,
        // time at both ends, free fall reaching the minimum exactly, an impact
        // on the last millisecond of the window, the hold judged at its edge,
        // a window running out, free fall across the wrap of the clock, and
        // clears with state to throw away.
        put(-32768, -32768, -32768, 32'h0000_0000, 1'b0);
        put(32767, 32767, 32767, 32'hFFFF_FFFF, 1'b0);
        put(0, 0, 0, 32'd4096, 1'b0);
        put(16, -16, 5, 32'd4245, 1'b0);
        put(0, 0, 0, 32'd4246, 1'b0);
        put(0, 0, 4096, 32'd4396, 1'b0);
        put(12000, 0, 0, 32'd4746, 1'b0);
        put(0, 0, 4096, 32'd7746, 1'b0);
        put(0, 0, 4096, 32'd7747, 1'b0);
        put(0, 0, 0, 32'd20000, 1'b0);
        put(0, 0, 0, 32'd20150, 1'b0);
        put(0, 0, 4096, 32'd20650, 1'b0);
        put(0, 0, 4096, 32'd20651, 1'b0);
        put(0, 0, 0, 32'hFFFF_FFA0, 1'b0);
        put(0, 0, 0, 32'h0000_0036, 1'b0);
        put(1, 2, 3, 32'd100, 1'b1);
        put(-1, -1, -1, 32'd200, 1'b0);
        put(0, 0, 0, 32'd300, 1'b0);
        put(0, 0, 0, 32'd450, 1'b0);
        put(32767, 0, 0, 32'd460, 1'b0);
        put(-32768, 32767, -1, 32'hAAAA_5555, 1'b1);
        put(0, 0, 0, 32'h5555_AAAA, 1'b0);

        // Typical levels and short times. The result side holds off for a
        // long stretch at the start, and halfway the sample side waits for
        // every pending result before carrying on.
        reconfigure($urandom_range(8_000_000, 20_000_000),
                    $urandom_range(60_000_000, 200_000_000),
                    16'($urandom_range(20, 300)), 16'($urandom_range(50, 600)),
                    16'($urandom_range(100, 2000)));
        long_hold_req = 1'b1;
        run_phase(sent + 50);
        wait_drained();
        run_phase(sent + 60);

        // Every sample below the top level is free fall and every nonzero one an
        // impact, all times zero: the window opens and is hit by the same sample.
        reconfigure(LEVEL_TOP, '0, 16'd0, 16'd0, 16'd0);
        run_phase(sent + 90);

        // Nothing counts as free fall or impact, all times at their largest.
        reconfigure('0, LEVEL_TOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(sent + 70);

        repeat (4) begin
            reconfigure(pick_level(), pick_level(), pick_ms(), pick_ms(), pick_ms());
            run_phase(sent + 110);
        end

        // Last stretch: reset settings again and no idling on either side.
        calm       = 1'b1;
        gap_rate   = 0;
        stall_rate = 0;
        reconfigure(RST_FREEFALL_LEVEL_SQ, RST_IMPACT_LEVEL_SQ, RST_FREEFALL_MIN_MS,
                    RST_WINDOW_MS, RST_HOLD_MS);
        run_phase(sent + 100);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Generous bound on the whole run; a hang ends here as a failure.
    initial begin : watchdog
        #1_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/afd_pkg.sv
hdl/afd_sample_if.sv
hdl/afd_result_if.sv
hdl/afd_mag_pipe.sv
hdl/accel_fall_detector_core.sv
tb/tb.sv
